// ===== rtl/rhht_pkg.sv =====
// Package: shared types and constants for the read-hold hash table.
package rhht_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 16;
  localparam int unsigned ALIGN_SHIFT_DEF = 4;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  localparam logic [1:0] KIND_LOOKUP  = 2'd0;
  localparam logic [1:0] KIND_ACQUIRE = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_ABSENT   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_LAST     = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] lock_key;
  } rhht_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] hold_count;
    logic [3:0]  slot_index;
  } rhht_rsp_t;

endpackage

// ===== rtl/rhht_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module rhht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/read_hold_hash_table.sv =====
// Top level: read-hold hash table with probe sequencer over slot memories.
//
//  channel | signals                         | transfer
//  --------+---------------------------------+-------------------------------
//  request | start, busy, req (kind,lock_key)| edge with start & !busy
//  result  | done, rsp (status,count,slot)   | one cycle, done high
//
// Steps: a request walks probe steps (memory read, then compare), then
// resolves; done rises in the next cycle with busy already low. A reserved
// key answers in the cycle after the transfer, with no walk.
// A rebuild scans every slot (read, then stash and clear), reinserts each
// live key by a probe walk to its chain end, then settles before the
// original walk restarts. After reset a clearing pass writes every slot
// empty, with busy high. The receiver cannot stall; results are never held.
module read_hold_hash_table #(
  parameter int unsigned TABLE_SLOTS = rhht_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned ALIGN_SHIFT = rhht_pkg::ALIGN_SHIFT_DEF,
  parameter int unsigned KEY_BITS    = rhht_pkg::KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rhht_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rhht_pkg::rhht_req_t req,
  output logic                done,
  output rhht_pkg::rhht_rsp_t rsp
);
  import rhht_pkg::*;

  localparam int unsigned IW    = $clog2(TABLE_SLOTS);
  localparam int unsigned NW    = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned LIMIT = 2 * TABLE_SLOTS + 8;
  localparam int unsigned PW    = $clog2(LIMIT + 1);
  // entry: key + count in one memory word
  localparam int unsigned EW    = KEY_BITS + COUNT_BITS;

  localparam logic [KEY_BITS-1:0]   TOMB  = '1;
  localparam logic [COUNT_BITS-1:0] CMAX  = '1;
  localparam logic [NW-1:0]         FULLN = NW'(TABLE_SLOTS - 1);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_READ    = 11'b00000000100,
    S_CMP     = 11'b00000001000,
    S_RESOLVE = 11'b00000010000,
    S_RB_RD   = 11'b00000100000,  // scan: read slot from main memory
    S_RB_CHK  = 11'b00001000000,  // scan: stash live entry, clear slot
    S_RB_INS  = 11'b00010000000,  // reinsert: read next stashed entry
    S_RB_GO   = 11'b00100000000,  // reinsert: start probe
    S_RB_PUT  = 11'b01000000000,  // reinsert: write entry at chain end
    S_RB_END  = 11'b10000000000   // last write lands, restart original walk
  } state_t;

  state_t state, state_next;

  // main slot memory
  logic          m_we;
  logic [IW-1:0] m_waddr, m_raddr;
  logic [EW-1:0] m_wdata, m_rdata;
  // stash memory used during rebuild
  logic          a_we;
  logic [IW-1:0] a_waddr, a_raddr;
  logic [EW-1:0] a_wdata, a_rdata;

  rhht_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_slots (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );
  rhht_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_stash (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata)
  );

  logic [1:0]            kind;
  logic [KEY_BITS-1:0]   key;
  logic [KEY_BITS-1:0]   pi, perturb;     // probe index and perturbation
  logic [PW-1:0]         steps;
  logic                  hit, ins_ok;
  logic [IW-1:0]         hit_slot, ins_slot;
  logic                  ins_empty;       // insertion slot was empty
  logic [COUNT_BITS-1:0] hit_count;
  logic                  rebuilt;         // rebuild done for this request
  logic [NW-1:0]         live, occ;
  logic [IW:0]           scan;            // sweep counter (clear / scan)
  logic [NW-1:0]         nstash, rix;
  logic [COUNT_BITS-1:0] rb_count;

  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_live;
  assign rd_key  = m_rdata[EW-1:COUNT_BITS];
  assign rd_cnt  = m_rdata[COUNT_BITS-1:0];
  assign rd_live = (rd_key != '0) && (rd_key != TOMB);

  logic [KEY_BITS-1:0] in_key;
  logic                in_rsv;
  assign in_key = KEY_BITS'(req.lock_key);
  assign in_rsv = (in_key == '0) || (in_key == TOMB);

  logic chain_end;
  assign chain_end = (rd_key == '0) || (steps == PW'(LIMIT - 1));

  assign busy = (state != S_IDLE);

  // original key kept across a rebuild
  logic [KEY_BITS-1:0] key_save;
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) key_save <= in_key;
  end

  // seed probe index from the key being walked
  logic [KEY_BITS-1:0] seed_key;
  logic                seed;
  always_comb begin
    seed_key = key;
    seed     = 1'b0;
    if (state == S_IDLE && start && !in_rsv) begin
      seed     = 1'b1;
      seed_key = in_key;
    end else if (state == S_RB_GO) begin
      seed     = 1'b1;
      seed_key = a_rdata[EW-1:COUNT_BITS];
    end else if (state == S_RB_END) begin
      seed     = 1'b1;
      seed_key = key_save;
    end
  end
  logic [KEY_BITS-1:0] seed_home;
  assign seed_home = KEY_BITS'((seed_key >> ALIGN_SHIFT) & KEY_BITS'(TABLE_SLOTS - 1));

  // stash is written in the scan cycle itself so it can be read right after
  always_comb begin
    m_raddr = pi[IW-1:0];
    if (state == S_RB_RD || state == S_RB_CHK) m_raddr = scan[IW-1:0];
    a_raddr = rix[IW-1:0];
    a_we    = (state == S_RB_CHK) && rd_live;
    a_waddr = nstash[IW-1:0];
    a_wdata = m_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      scan  <= '0;
      live  <= '0;
      occ   <= '0;
      done  <= 1'b0;
      m_we  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      m_we  <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          m_we    <= 1'b1;
          m_waddr <= scan[IW-1:0];
          m_wdata <= '0;
          scan    <= scan + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            kind    <= req.kind;
            key     <= in_key;
            rebuilt <= 1'b0;
            if (in_rsv) begin
              done <= 1'b1;
              rsp  <= '{ST_ABSENT, 16'd0, 4'd0};
            end
          end
        end
        S_READ: ;
        S_CMP: begin
          steps   <= steps + 1'b1;
          pi      <= (pi << 2) + pi + perturb + 1'b1;
          perturb <= perturb >> 5;
          if (rd_key == key && !hit) begin
            hit       <= 1'b1;
            hit_slot  <= pi[IW-1:0];
            hit_count <= rd_cnt;
          end else if (!ins_ok && (rd_key == '0 || rd_key == TOMB)) begin
            ins_ok    <= 1'b1;
            ins_slot  <= pi[IW-1:0];
            ins_empty <= (rd_key == '0);
          end
        end
        S_RESOLVE: begin
          if (hit) begin
            unique case (kind)
              KIND_ACQUIRE: begin
                if (hit_count == CMAX) begin
                  rsp <= '{ST_OVERFLOW, 16'(hit_count), 4'(hit_slot)};
                end else begin
                  m_we    <= 1'b1;
                  m_waddr <= hit_slot;
                  m_wdata <= {key, hit_count + 1'b1};
                  rsp     <= '{ST_HIT, 16'(hit_count + 1'b1), 4'(hit_slot)};
                end
                done <= 1'b1;
              end
              KIND_RELEASE: begin
                m_we    <= 1'b1;
                m_waddr <= hit_slot;
                if (hit_count <= COUNT_BITS'(1)) begin
                  m_wdata <= {TOMB, {COUNT_BITS{1'b0}}};
                  if (live != '0) live <= live - 1'b1;
                  rsp <= '{ST_LAST, 16'd0, 4'(hit_slot)};
                end else begin
                  m_wdata <= {key, hit_count - 1'b1};
                  rsp     <= '{ST_HIT, 16'(hit_count - 1'b1), 4'(hit_slot)};
                end
                done <= 1'b1;
              end
              default: begin
                rsp  <= '{ST_HIT, 16'(hit_count), 4'(hit_slot)};
                done <= 1'b1;
              end
            endcase
          end else if (kind == KIND_ACQUIRE) begin
            if (occ >= FULLN && !rebuilt) begin
              scan   <= '0;
              nstash <= '0;
            end else if (live >= FULLN || !ins_ok) begin
              rsp  <= '{ST_FULL, 16'd0, 4'd0};
              done <= 1'b1;
            end else begin
              m_we    <= 1'b1;
              m_waddr <= ins_slot;
              m_wdata <= {key, COUNT_BITS'(1)};
              if (ins_empty) occ <= occ + 1'b1;
              live <= live + 1'b1;
              rsp  <= '{ST_NEW, 16'd1, 4'(ins_slot)};
              done <= 1'b1;
            end
          end else begin
            rsp  <= '{ST_ABSENT, 16'd0, 4'd0};
            done <= 1'b1;
          end
        end
        S_RB_RD: ;
        S_RB_CHK: begin
          if (rd_live) nstash <= nstash + 1'b1;
          m_we    <= 1'b1;
          m_waddr <= scan[IW-1:0];
          m_wdata <= '0;
          scan    <= scan + 1'b1;
          rix     <= '0;
        end
        S_RB_INS: ;
        S_RB_GO: begin
          key      <= a_rdata[EW-1:COUNT_BITS];
          rb_count <= a_rdata[COUNT_BITS-1:0];
          rebuilt  <= 1'b1;
        end
        S_RB_PUT: begin
          if (ins_ok) begin
            m_we    <= 1'b1;
            m_waddr <= ins_slot;
            m_wdata <= {key, rb_count};
          end
          rix <= rix + 1'b1;
        end
        S_RB_END: begin
          key     <= key_save;
          live    <= nstash;
          occ     <= nstash;
          rebuilt <= 1'b1;
        end
        default: ;
      endcase
      // (re)start a probe walk
      if (seed) begin
        steps   <= '0;
        hit     <= 1'b0;
        ins_ok  <= 1'b0;
        pi      <= seed_home;
        perturb <= seed_home;
      end
    end
  end

  logic probe_done;
  assign probe_done = (rd_key == key) || chain_end;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (scan == (IW+1)'(TABLE_SLOTS - 1)) state_next = S_IDLE;
      S_IDLE:    if (start && !in_rsv) state_next = S_READ;
      S_READ:    state_next = S_CMP;
      S_CMP:     state_next = probe_done ? (rebuilt && key != key_save ? S_RB_PUT
                                                                        : S_RESOLVE)
                                         : S_READ;
      S_RESOLVE: state_next = (!hit && kind == KIND_ACQUIRE && occ >= FULLN && !rebuilt)
                              ? S_RB_RD : S_IDLE;
      S_RB_RD:   state_next = S_RB_CHK;
      S_RB_CHK:  state_next = (scan == (IW+1)'(TABLE_SLOTS - 1))
                              ? ((nstash != '0 || rd_live) ? S_RB_INS : S_RB_END)
                              : S_RB_RD;
      S_RB_INS:  state_next = S_RB_GO;
      S_RB_GO:   state_next = S_READ;
      S_RB_PUT:  state_next = (rix + 1'b1 == nstash) ? S_RB_END : S_RB_INS;
      S_RB_END:  state_next = S_READ;
      default:   state_next = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/read_hold_hash_table_checker.sv =====
// Checker: port-level properties of the read-hold hash table, and its bind.
module read_hold_hash_table_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input rhht_pkg::rhht_rsp_t rsp
);
  import rhht_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("no busy after accept");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.status <= ST_OVERFLOW) else $error("bad status");
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == ST_ABSENT || rsp.status == ST_FULL)
      |-> rsp.hold_count == 16'd0 && rsp.slot_index == 4'd0) else $error("absent nonzero");
  a_new_one: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_NEW |-> rsp.hold_count == 16'd1) else $error("new count");
  a_reset_busy: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy) else $error("no clear pass");
endmodule

bind read_hold_hash_table read_hold_hash_table_checker u_chk (
  .clk, .rst, .start, .busy, .done, .rsp
);
